// ===== hdl/pncc_pkg.sv =====
// ----------------------------------------------------------------------------
// pncc_pkg
// Shared widths, job record and controller states for the patch NCC block.
// ----------------------------------------------------------------------------
package pncc_pkg;

  localparam int unsigned MAX_PIXELS = 1024;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);

  // largest sum: every pixel pair at full scale
  localparam longint unsigned MAX_SUM = 64'(MAX_PIXELS) * 64'd65025;
  localparam int unsigned SUM_W       = $clog2(MAX_SUM + 1);
  localparam int unsigned SQ_W        = 2 * PIX_W;
  localparam int unsigned PROD_W      = 2 * SUM_W;

  // score is Q1.16, search runs one bit per cycle from the integer bit down
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SCORE_W  = FRAC_W + 1;
  localparam int unsigned STEP_W   = $clog2(SCORE_W);
  localparam int unsigned REM_W    = PROD_W + 2 * FRAC_W + 2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SUM_W-1:0] energy_a;
    logic [SUM_W-1:0] energy_b;
    logic [SUM_W-1:0] cross_sum;
    logic             too_long;
  } pncc_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_MUL_CC,
    ST_ITER,
    ST_DONE
  } pncc_state_e;

endpackage

// ===== hdl/pncc_if.sv =====
// ----------------------------------------------------------------------------
// pncc_if
// Valid/ready channels for pixel pairs in and correlation results out.
// ----------------------------------------------------------------------------
interface pncc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pncc_pkg::PIX_W-1:0]   pixel_a;
  logic [pncc_pkg::PIX_W-1:0]   pixel_b;
  logic                         last_pixel;

  modport source (output valid, output pixel_a, output pixel_b, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_a, input pixel_b, input last_pixel,
                  output ready);
endinterface

interface pncc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pncc_pkg::SCORE_W-1:0] score;
  logic                         zero_energy;
  logic                         too_long;

  modport source (output valid, output score, output zero_energy, output too_long,
                  input ready);
  modport sink   (input valid, input score, input zero_energy, input too_long,
                  output ready);
endinterface

// ===== hdl/patch_normalized_cross_correlation_top.sv =====
// ----------------------------------------------------------------------------
// patch_normalized_cross_correlation_top
// Un-centred normalized cross-correlation of two 8-bit pixel patches.
// ----------------------------------------------------------------------------
// Usage:
//   px_i  carries one pixel pair per transfer (pixel_a, pixel_b, last_pixel).
//         The accumulator takes one pair every cycle; ready drops only while
//         the two-entry job queue is full.
//   res_o carries one result per patch (score in Q1.16, zero_energy,
//         too_long), sent after the pair marked last.
//   After the transfer of the last pair, a job goes through the queue, two
//   passes through the shared 26x26 multiplier, a bit-serial score search
//   (one score bit per cycle) and the result register; a zero-energy patch
//   skips the multiplier and the search. Pairs stream at one per cycle while
//   the queue has room; the score engine takes one patch at a time, so patches
//   arriving faster than it finishes them fill the queue and throttle px_i.
//   Pairs beyond MAX_PIXELS are accepted but left out of the sums and flag
//   too_long.
//   Reset clears the sums, empties the queue and clears the result valid flag.
//   A stalled res_o holds its result; the engine waits on it while the
//   accumulator keeps taking pairs until the queue fills.
// ----------------------------------------------------------------------------
module patch_normalized_cross_correlation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pncc_in_if.sink     px_i,
  pncc_out_if.source  res_o
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  pncc_pkg::pncc_job_t push_job, pop_job;

  pncc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .px_i        (px_i),
    .job_valid_o (push_valid),
    .job_o       (push_job),
    .job_ready_i (push_ready)
  );

  pncc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  pncc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/pncc_front.sv =====
// ----------------------------------------------------------------------------
// pncc_front
// Accepts pixel pairs, keeps the running energy and cross sums, and hands a
// finished patch to the job queue on the pair marked last.
// ----------------------------------------------------------------------------
module pncc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pncc_in_if.sink              px_i,
  output logic                 job_valid_o,
  output pncc_pkg::pncc_job_t  job_o,
  input  logic                 job_ready_i
);

  logic [pncc_pkg::SUM_W-1:0] energy_a_q, energy_a_d;
  logic [pncc_pkg::SUM_W-1:0] energy_b_q, energy_b_d;
  logic [pncc_pkg::SUM_W-1:0] cross_q, cross_d;
  logic [pncc_pkg::CNT_W-1:0] count_q, count_d;
  logic                       ovf_q, ovf_d;

  logic                       room;
  logic                       xfer;
  logic [pncc_pkg::SQ_W-1:0]  sq_a, sq_b, prod_ab;
  logic [pncc_pkg::SUM_W-1:0] acc_a, acc_b, acc_c;

  assign px_i.ready = job_ready_i;
  assign xfer       = px_i.valid && px_i.ready;
  assign room       = count_q < pncc_pkg::CNT_W'(pncc_pkg::MAX_PIXELS);

  assign sq_a    = pncc_pkg::SQ_W'(px_i.pixel_a) * pncc_pkg::SQ_W'(px_i.pixel_a);
  assign sq_b    = pncc_pkg::SQ_W'(px_i.pixel_b) * pncc_pkg::SQ_W'(px_i.pixel_b);
  assign prod_ab = pncc_pkg::SQ_W'(px_i.pixel_a) * pncc_pkg::SQ_W'(px_i.pixel_b);

  // drop the pair from the sums once the patch is full
  assign acc_a = room ? energy_a_q + pncc_pkg::SUM_W'(sq_a)    : energy_a_q;
  assign acc_b = room ? energy_b_q + pncc_pkg::SUM_W'(sq_b)    : energy_b_q;
  assign acc_c = room ? cross_q    + pncc_pkg::SUM_W'(prod_ab) : cross_q;

  assign job_valid_o        = px_i.valid && px_i.last_pixel;
  assign job_o.energy_a     = acc_a;
  assign job_o.energy_b     = acc_b;
  assign job_o.cross_sum    = acc_c;
  assign job_o.too_long     = ovf_q || !room;

  always_comb begin
    energy_a_d = energy_a_q;
    energy_b_d = energy_b_q;
    cross_d    = cross_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    if (xfer) begin
      if (px_i.last_pixel) begin
        energy_a_d = '0;
        energy_b_d = '0;
        cross_d    = '0;
        count_d    = '0;
        ovf_d      = 1'b0;
      end else begin
        energy_a_d = acc_a;
        energy_b_d = acc_b;
        cross_d    = acc_c;
        count_d    = room ? count_q + 1'b1 : count_q;
        ovf_d      = ovf_q || !room;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_a_q <= '0;
      energy_b_q <= '0;
      cross_q    <= '0;
      count_q    <= '0;
      ovf_q      <= 1'b0;
    end else begin
      energy_a_q <= energy_a_d;
      energy_b_q <= energy_b_d;
      cross_q    <= cross_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  a_ovf_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !px_i.last_pixel && !room) |=> ovf_q)
    else $error("overflow flag not set on an ignored pair");
`endif

endmodule

// ===== hdl/pncc_queue.sv =====
// ----------------------------------------------------------------------------
// pncc_queue
// Short job queue between the accumulator and the score engine.
// ----------------------------------------------------------------------------
module pncc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  pncc_pkg::pncc_job_t  push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output pncc_pkg::pncc_job_t  pop_data_o
);

  localparam int unsigned PTR_W = (pncc_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(pncc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(pncc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pncc_pkg::QUEUE_DEPTH - 1);

  pncc_pkg::pncc_job_t mem_q [pncc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [PTR_W-1:0]    rptr_q, rptr_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                push, pop;

  assign push_ready_o = fill_q != FILL_W'(pncc_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/pncc_back.sv =====
// ----------------------------------------------------------------------------
// pncc_back
// Score engine: forms energy_a*energy_b and cross^2 on one shared multiplier,
// then finds the Q1.16 score one bit per cycle with a restoring search; zero-energy jobs skip both.
// ----------------------------------------------------------------------------
module pncc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  pncc_pkg::pncc_job_t  job_i,
  pncc_out_if.source           res_o
);

  localparam logic [pncc_pkg::SCORE_W-1:0] SCORE_ONE =
    pncc_pkg::SCORE_W'(1) << pncc_pkg::FRAC_W;

  pncc_pkg::pncc_state_e state_q, state_d;

  pncc_pkg::pncc_job_t          job_q;
  logic [pncc_pkg::PROD_W-1:0]  p_q;
  logic [pncc_pkg::REM_W-1:0]   rem_q, x_q, y_q;
  logic [pncc_pkg::STEP_W-1:0]  k_q;
  logic [pncc_pkg::SCORE_W-1:0] s_q;
  logic                         zero_q;

  logic                         out_valid_q;
  logic [pncc_pkg::SCORE_W-1:0] out_score_q;
  logic                         out_zero_q;
  logic                         out_long_q;

  logic [pncc_pkg::SUM_W-1:0]   mul_x, mul_y;
  logic [pncc_pkg::PROD_W-1:0]  prod;
  logic [pncc_pkg::REM_W-1:0]   trial;
  logic                         take;
  logic                         job_zero;
  logic                         load_out;
  logic                         out_free;

  assign mul_x = (state_q == pncc_pkg::ST_MUL_AB) ? job_q.energy_a : job_q.cross_sum;
  assign mul_y = (state_q == pncc_pkg::ST_MUL_AB) ? job_q.energy_b : job_q.cross_sum;
  assign prod  = pncc_pkg::PROD_W'(mul_x) * pncc_pkg::PROD_W'(mul_y);

  // t^2*P - s^2*P for t = s + 2^k, kept pre-shifted in x_q and y_q
  assign trial    = x_q + y_q;
  assign take     = trial <= rem_q;
  assign job_zero = (job_i.energy_a == '0) || (job_i.energy_b == '0);
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      pncc_pkg::ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          state_d = job_zero ? pncc_pkg::ST_DONE : pncc_pkg::ST_MUL_AB;
        end
      end
      pncc_pkg::ST_MUL_AB: state_d = pncc_pkg::ST_MUL_CC;
      pncc_pkg::ST_MUL_CC: state_d = pncc_pkg::ST_ITER;
      pncc_pkg::ST_ITER: begin
        if (k_q == '0) begin
          state_d = pncc_pkg::ST_DONE;
        end
      end
      pncc_pkg::ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = pncc_pkg::ST_IDLE;
        end
      end
      default: state_d = pncc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pncc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pncc_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_q  <= job_i;
          zero_q <= job_zero;
          s_q    <= '0;
        end
      end
      pncc_pkg::ST_MUL_AB: begin
        p_q <= prod;
      end
      pncc_pkg::ST_MUL_CC: begin
        rem_q <= pncc_pkg::REM_W'({prod, {(2 * pncc_pkg::FRAC_W){1'b0}}});
        y_q   <= pncc_pkg::REM_W'({p_q, {(2 * pncc_pkg::FRAC_W){1'b0}}});
        x_q   <= '0;
        k_q   <= pncc_pkg::STEP_W'(pncc_pkg::FRAC_W);
      end
      pncc_pkg::ST_ITER: begin
        if (take) begin
          rem_q    <= rem_q - trial;
          x_q      <= (x_q >> 1) + y_q;
          s_q[k_q] <= 1'b1;
        end else begin
          x_q <= x_q >> 1;
        end
        y_q <= y_q >> 2;
        k_q <= k_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register: hold until transfer, reload only when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_score_q <= s_q;
      out_zero_q  <= zero_q;
      out_long_q  <= job_q.too_long;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.score       = out_score_q;
  assign res_o.zero_energy = out_zero_q;
  assign res_o.too_long    = out_long_q;

`ifndef SYNTHESIS
  a_zero_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.zero_energy) |-> (res_o.score == '0))
    else $error("zero-energy result carries a nonzero score");
  a_score_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.score <= SCORE_ONE))
    else $error("score above 1.0");
  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pncc_pkg::ST_ITER && k_q == '0) |=> (state_q == pncc_pkg::ST_DONE))
    else $error("search did not finish after the last bit");
`endif

endmodule
